/* rtl/core/fdlp_pkg.sv */
`default_nettype none

package fdlp_pkg;

    // Fixed character codes and limits
    localparam logic [7:0]  CH_NEWLINE  = 8'd10;
    localparam logic [7:0]  CH_STOP     = 8'd115;
    localparam logic [7:0]  CH_ZERO     = 8'd48;
    localparam logic [7:0]  DIGIT_BELOW = 8'd47;
    localparam logic [7:0]  DIGIT_ABOVE = 8'd58;
    localparam logic [15:0] VALUE_CAP   = 16'd65535;

    // Configuration reset values
    localparam logic [7:0] RST_EXPECTED_TAG   = 8'd83;
    localparam logic [7:0] RST_START_CHAR     = 8'd60;
    localparam logic [7:0] RST_END_CHAR       = 8'd62;
    localparam logic [7:0] RST_SEPARATOR_CHAR = 8'd44;

    typedef enum logic [1:0] {
        REG_EXPECTED_TAG   = 2'd0,
        REG_START_CHAR     = 2'd1,
        REG_END_CHAR       = 2'd2,
        REG_SEPARATOR_CHAR = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_TAG    = 2'd0,
        PH_SEP    = 2'd1,
        PH_VALUES = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_VALUES = 2'd1,
        KIND_STOP   = 2'd2,
        KIND_OTHER  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RO_IDLE = 2'd0,
        RO_READ = 2'd1,
        RO_SHOW = 2'd2
    } ro_state_t;

    typedef struct packed {
        logic        clamped;
        logic [15:0] value;
    } store_word_t;

    typedef struct packed {
        logic go_values;
        logic go_stop;
        logic overflow;
    } ro_req_t;

    typedef struct packed {
        logic [7:0] expected_tag;
        logic [7:0] start_char;
        logic [7:0] end_char;
        logic [7:0] separator_char;
    } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/fdlp_store.sv */
`default_nettype none

// Value store: one write port, one read port, registered read data.
module fdlp_store
    import fdlp_pkg::*;
#(
    parameter int MAX_VALUES = 8,
    localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1
)
(
    input  wire logic        clk,
    input  wire logic        wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire store_word_t wr_data,
    input  wire logic        rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output store_word_t      rd_data
);

    store_word_t mem [MAX_VALUES];
    store_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/fdlp_parser.sv */
`default_nettype none

// Byte-level frame parser: tracks the frame, builds values, writes them to the store.
module fdlp_parser
    import fdlp_pkg::*;
#(
    parameter int MAX_FRAME_LEN = 64,
    parameter int MAX_VALUES    = 8,
    localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1,
    localparam int CW = $clog2(MAX_VALUES + 1),
    localparam int LW = $clog2(MAX_FRAME_LEN + 1)
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_ok,
    input  wire logic [7:0]  rx_byte,
    input  wire cfg_t        cfg,
    output logic             wr_en,
    output logic [AW-1:0]    wr_addr,
    output store_word_t      wr_data,
    output ro_req_t          req,
    output logic [CW-1:0]    req_count
);

    logic          in_frame_reg, in_frame_next;
    logic [LW-1:0] len_reg, len_next;
    phase_t        phase_reg, phase_next;
    kind_t         kind_reg, kind_next;
    logic [15:0]   acc_reg, acc_next;
    logic          cur_clamp_reg, cur_clamp_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;

    // Byte decode
    logic          ev_start, ev_body, ev_end, ev_value_end, ev_digit, ev_sep;
    logic          len_full, is_digit, store_room;
    logic [19:0]   acc_wide;
    logic [3:0]    digit;

    always_comb
    begin
        len_full     = (len_reg >= LW'(MAX_FRAME_LEN));
        is_digit     = (rx_byte > DIGIT_BELOW) && (rx_byte < DIGIT_ABOVE);
        store_room   = (count_reg < CW'(MAX_VALUES));
        digit        = 4'(rx_byte - CH_ZERO);
        acc_wide     = 20'({acc_reg, 3'b000}) + 20'({acc_reg, 1'b0}) + 20'(digit);
        ev_start     = byte_ok && !in_frame_reg && (rx_byte == cfg.start_char);
        ev_body      = byte_ok && in_frame_reg && !len_full && (rx_byte != CH_NEWLINE);
        ev_end       = ev_body && (rx_byte == cfg.end_char);
        ev_value_end = ev_end && (kind_reg == KIND_VALUES) && (phase_reg == PH_VALUES);
        ev_digit     = ev_body && !ev_end && (phase_reg == PH_VALUES)
                       && (kind_reg == KIND_VALUES) && is_digit;
        ev_sep       = ev_body && !ev_end && (phase_reg == PH_VALUES)
                       && (kind_reg == KIND_VALUES) && !is_digit
                       && (rx_byte == cfg.separator_char);
    end

    // Next state
    always_comb
    begin
        in_frame_next  = in_frame_reg;
        len_next       = len_reg;
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        acc_next       = acc_reg;
        cur_clamp_next = cur_clamp_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        if (ev_start)
        begin
            in_frame_next  = 1'b1;
            len_next       = LW'(1);
            phase_next     = PH_TAG;
            kind_next      = KIND_NONE;
            acc_next       = '0;
            cur_clamp_next = 1'b0;
            count_next     = '0;
            ovf_next       = 1'b0;
        end
        else if (byte_ok && in_frame_reg)
        begin
            if (!len_full)
            begin
                len_next = len_reg + LW'(1);
            end
            if (!ev_body || ev_end)
            begin
                // newline, end marker or length limit: drop out of the frame
                in_frame_next = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_TAG:
                    begin
                        if (rx_byte == cfg.expected_tag)
                        begin
                            kind_next  = KIND_VALUES;
                            phase_next = PH_SEP;
                        end
                        else if (rx_byte == CH_STOP)
                        begin
                            kind_next  = KIND_STOP;
                            phase_next = PH_VALUES;
                        end
                        else
                        begin
                            kind_next  = KIND_OTHER;
                            phase_next = PH_VALUES;
                        end
                    end
                    PH_SEP:
                    begin
                        phase_next = PH_VALUES;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (ev_digit)
            begin
                if (acc_wide > 20'(VALUE_CAP))
                begin
                    acc_next       = VALUE_CAP;
                    cur_clamp_next = 1'b1;
                end
                else
                begin
                    acc_next = acc_wide[15:0];
                end
            end
            if (ev_sep || ev_value_end)
            begin
                acc_next       = '0;
                cur_clamp_next = 1'b0;
                if (store_room)
                begin
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
        end
    end

    // Outputs
    always_comb
    begin
        wr_en           = (ev_sep || ev_value_end) && store_room;
        wr_addr         = AW'(count_reg);
        wr_data.clamped = cur_clamp_reg;
        wr_data.value   = acc_reg;
        req.go_values   = ev_value_end;
        req.go_stop     = ev_end && (kind_reg == KIND_STOP);
        req.overflow    = ovf_next;
        req_count       = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            len_reg       <= '0;
            phase_reg     <= PH_TAG;
            kind_reg      <= KIND_NONE;
            acc_reg       <= '0;
            cur_clamp_reg <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            in_frame_reg  <= in_frame_next;
            len_reg       <= len_next;
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            acc_reg       <= acc_next;
            cur_clamp_reg <= cur_clamp_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/fdlp_readout.sv */
`default_nettype none

// Readout sequencer: after an end marker, walks the store (or gives one stop result) and presents one result at a time.
module fdlp_readout
    import fdlp_pkg::*;
#(
    parameter int MAX_VALUES = 8,
    localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1,
    localparam int CW = $clog2(MAX_VALUES + 1)
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ro_req_t     req,
    input  wire logic [CW-1:0] req_count,
    input  wire store_word_t rd_data,
    input  wire logic        out_stall,
    output logic             rd_en,
    output logic [AW-1:0]    rd_addr,
    output logic             busy,
    output logic             out_valid,
    output logic [15:0]      value,
    output logic [2:0]       value_index,
    output logic             last,
    output logic             stop_frame,
    output logic             clamped,
    output logic             values_dropped
);

    ro_state_t     state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          stop_reg, stop_next;
    logic          is_last;

    assign is_last = stop_reg || ((idx_reg + CW'(1)) == count_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        stop_next  = stop_reg;
        unique case (state_reg)
            RO_IDLE:
            begin
                if (req.go_values)
                begin
                    state_next = RO_READ;
                    idx_next   = '0;
                    count_next = req_count;
                    ovf_next   = req.overflow;
                    stop_next  = 1'b0;
                end
                else if (req.go_stop)
                begin
                    state_next = RO_SHOW;
                    idx_next   = '0;
                    stop_next  = 1'b1;
                end
            end
            RO_READ:
            begin
                state_next = RO_SHOW;
            end
            RO_SHOW:
            begin
                if (!out_stall)
                begin
                    if (is_last)
                    begin
                        state_next = RO_IDLE;
                    end
                    else
                    begin
                        state_next = RO_READ;
                        idx_next   = idx_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = RO_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        rd_en          = (state_reg == RO_READ);
        rd_addr        = AW'(idx_reg);
        busy           = (state_reg != RO_IDLE);
        out_valid      = (state_reg == RO_SHOW);
        value          = stop_reg ? '0 : rd_data.value;
        value_index    = 3'(idx_reg);
        last           = is_last;
        stop_frame     = stop_reg;
        clamped        = !stop_reg && rd_data.clamped;
        values_dropped = !stop_reg && ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RO_IDLE;
            idx_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            stop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            stop_reg  <= stop_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/framed_decimal_list_parser.sv */
`default_nettype none

// Framed decimal list parser. Feed received serial bytes on rx_byte; frames look like
// start_char, tag, one skipped byte, comma-style separated decimal numbers, end_char.
// A frame tagged with expected_tag stores up to MAX_VALUES values in a small
// synchronous store; at its end marker they come out in order, the final one with
// last set. Values above 65535 are held at 65535 and flagged clamped; values that do
// not fit the store are dropped and values_dropped is set on every result of that
// frame. A frame tagged 's', if that is not expected_tag, gives one stop_frame result.
// Any other tag, a newline, or a frame longer than MAX_FRAME_LEN bytes gives nothing.
// Rate: one byte per cycle while no results are pending. An end marker that releases
// results raises in_stall until the last result is taken: each stored value is read
// from the store, then shown until out_stall is low; a stop result is only shown.
// Write configuration registers only while the block is idle.
module framed_decimal_list_parser
    import fdlp_pkg::*;
#(
    parameter int MAX_FRAME_LEN = 64,
    parameter int MAX_VALUES    = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,

    // byte request channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,

    // result request channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      value,
    output logic [2:0]       value_index,
    output logic             last,
    output logic             stop_frame,
    output logic             clamped,
    output logic             values_dropped
);

    localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int CW = $clog2(MAX_VALUES + 1);

    cfg_t          cfg_reg, cfg_next;
    logic          busy;
    logic          byte_ok;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    store_word_t   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    store_word_t   rd_data;
    ro_req_t       req;
    logic [CW-1:0] req_count;

    // Configuration registers: decode the index and update the one addressed.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_EXPECTED_TAG:   cfg_next.expected_tag   = cfg_data;
                REG_START_CHAR:     cfg_next.start_char     = cfg_data;
                REG_END_CHAR:       cfg_next.end_char       = cfg_data;
                REG_SEPARATOR_CHAR: cfg_next.separator_char = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_tag   <= RST_EXPECTED_TAG;
            cfg_reg.start_char     <= RST_START_CHAR;
            cfg_reg.end_char       <= RST_END_CHAR;
            cfg_reg.separator_char <= RST_SEPARATOR_CHAR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Hold off new bytes while the readout walks the store or a result waits.
    assign in_stall = busy;
    assign byte_ok  = in_valid && !busy;

    fdlp_parser #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN),
        .MAX_VALUES    (MAX_VALUES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ok   (byte_ok),
        .rx_byte   (rx_byte),
        .cfg       (cfg_reg),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .req       (req),
        .req_count (req_count)
    );

    fdlp_store #(
        .MAX_VALUES (MAX_VALUES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The store's read register doubles as the output register: it only
    // advances on a read, so a stalled result holds.
    fdlp_readout #(
        .MAX_VALUES (MAX_VALUES)
    ) u_readout (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .req_count      (req_count),
        .rd_data        (rd_data),
        .out_stall      (out_stall),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .busy           (busy),
        .out_valid      (out_valid),
        .value          (value),
        .value_index    (value_index),
        .last           (last),
        .stop_frame     (stop_frame),
        .clamped        (clamped),
        .values_dropped (values_dropped)
    );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fdlp_pkg::*;

    localparam int MAX_LEN      = 64;
    localparam int MAX_VALS     = 8;
    localparam int IDLE_PCT     = 16;   // percent of cycles a side sits out
    localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
    localparam int SETTLE       = 8;    // quiet cycles before a register write
    localparam int DRAIN_CYCLES = 20;   // quiet cycles at the end of the run
    localparam int STUCK_LIMIT  = 2500; // cycles with no request moving on any port
    localparam int PHASE_BYTES  = 4;    // minimum random bytes per configuration phase
    localparam int PHASE_HITS   = 2;    // results wanted per phase before moving on
    localparam int PHASE_CAP    = 30;   // give up on rare results after this many bytes

    // One output request of the parser, field by field.
    typedef struct packed {
        logic [15:0] value;
        logic [2:0]  idx;
        logic        last;
        logic        stop;
        logic        clamped;
        logic        dropped;
    } frame_result_t;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    cfg_reg_t    cfg_index = REG_EXPECTED_TAG;
    logic [7:0]  cfg_data  = 8'd0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte   = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] value;
    logic [2:0]  value_index;
    logic        last;
    logic        stop_frame;
    logic        clamped;
    logic        values_dropped;

    framed_decimal_list_parser #(
        .MAX_FRAME_LEN (MAX_LEN),
        .MAX_VALUES    (MAX_VALS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .value          (value),
        .value_index    (value_index),
        .last           (last),
        .stop_frame     (stop_frame),
        .clamped        (clamped),
        .values_dropped (values_dropped)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame parser predictor: its own copy of the registers and the
    // frame state, advanced once per accepted byte request.
    // ------------------------------------------------------------------
    cfg_t          pr_cfg        = {RST_EXPECTED_TAG, RST_START_CHAR,
                                    RST_END_CHAR, RST_SEPARATOR_CHAR};
    logic          pr_open       = 1'b0;
    int            pr_len        = 0;
    phase_t        pr_phase      = PH_TAG;
    kind_t         pr_kind       = KIND_NONE;
    int            pr_acc        = 0;
    int            pr_count      = 0;
    logic [15:0]   pr_store [0:MAX_VALS-1];
    logic [31:0]   pr_clamp_bits = '0;
    logic          pr_dropped    = 1'b0;
    logic          pr_cur_clamp  = 1'b0;
    frame_result_t fresh [$];   // results released by the latest byte

    frame_result_t pending_results [$];
    int            results_issued = 0;
    int            mismatches     = 0;

    // Sender-side view of the registers, used to shape the frames.
    cfg_t          cur_cfg = {RST_EXPECTED_TAG, RST_START_CHAR,
                              RST_END_CHAR, RST_SEPARATOR_CHAR};

    // Directed plan: a flat byte list cut into rows. A row with a typed
    // expectation carries its result count (0..2) and the results; -1 means
    // the predictor supplies them.
    logic [7:0]    plan_bytes [$];
    int            row_first [$];
    int            row_len [$];
    int            row_typed [$];
    frame_result_t row_want0 [$];
    frame_result_t row_want1 [$];
    int            row_mark = 0;

    logic [7:0]    burst [$];       // bytes of one random frame
    int            typed_row = -1;  // travels with the byte request
    int            hold_seq  = 0;   // bump to start the long hold-off
    int            rand_bytes = 0;

    function automatic frame_result_t pack_result(input int v, input int k, input logic lst,
                                                  input logic stp, input logic clp,
                                                  input logic drp);
        frame_result_t r;
        r.value   = v[15:0];
        r.idx     = k[2:0];
        r.last    = lst;
        r.stop    = stp;
        r.clamped = clp;
        r.dropped = drp;
        return r;
    endfunction

    // Close the number being accumulated: store it, or note the overflow.
    function automatic void close_number();
        if (pr_count < MAX_VALS)
        begin
            pr_store[pr_count] = pr_acc[15:0];
            if (pr_cur_clamp)
                pr_clamp_bits[pr_count] = 1'b1;
            pr_count++;
        end
        else
            pr_dropped = 1'b1;
        pr_acc       = 0;
        pr_cur_clamp = 1'b0;
    endfunction

    // Advance the predictor by one byte; released results land in fresh.
    function automatic int parse_byte(input logic [7:0] b);
        int k;
        int next;
        fresh.delete();
        if (!pr_open)
        begin
            if (b == pr_cfg.start_char)
            begin
                pr_open       = 1'b1;
                pr_len        = 1;
                pr_phase      = PH_TAG;
                pr_kind       = KIND_NONE;
                pr_acc        = 0;
                pr_count      = 0;
                pr_clamp_bits = '0;
                pr_dropped    = 1'b0;
                pr_cur_clamp  = 1'b0;
            end
            return 0;
        end
        // length limit wins over everything, even the end marker
        if (pr_len >= MAX_LEN)
        begin
            pr_open = 1'b0;
            return 0;
        end
        pr_len++;
        if (b == CH_NEWLINE)
        begin
            pr_open = 1'b0;
            return 0;
        end
        if (b == pr_cfg.end_char)
        begin
            pr_open = 1'b0;
            if (pr_kind == KIND_STOP)
            begin
                fresh.push_back(pack_result(0, 0, 1'b1, 1'b1, 1'b0, 1'b0));
                return 1;
            end
            if (pr_kind != KIND_VALUES || pr_phase != PH_VALUES)
                return 0;
            close_number();
            for (k = 0; k < pr_count; k++)
                fresh.push_back(pack_result(pr_store[k], k, k + 1 == pr_count, 1'b0,
                                            pr_clamp_bits[k], pr_dropped));
            return pr_count;
        end
        if (pr_phase == PH_TAG)
        begin
            // the configured tag is tested ahead of the stop letter
            if (b == pr_cfg.expected_tag)
            begin
                pr_kind  = KIND_VALUES;
                pr_phase = PH_SEP;
            end
            else
            begin
                pr_kind  = (b == CH_STOP) ? KIND_STOP : KIND_OTHER;
                pr_phase = PH_VALUES;
            end
            return 0;
        end
        if (pr_phase == PH_SEP)
        begin
            pr_phase = PH_VALUES;
            return 0;
        end
        if (pr_kind != KIND_VALUES)
            return 0;
        // a digit stays a digit even when it equals the separator
        if (b > DIGIT_BELOW && b < DIGIT_ABOVE)
        begin
            next = pr_acc * 10 + (b - CH_ZERO);
            if (next > VALUE_CAP)
            begin
                next         = VALUE_CAP;
                pr_cur_clamp = 1'b1;
            end
            pr_acc = next;
        end
        else if (b == pr_cfg.separator_char)
            close_number();
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: everything sampled at the rising edge, so all reads see
    // the values from before the edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        frame_result_t want;
        int n;
        int k;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_EXPECTED_TAG:   pr_cfg.expected_tag   = cfg_data;
                    REG_START_CHAR:     pr_cfg.start_char     = cfg_data;
                    REG_END_CHAR:       pr_cfg.end_char       = cfg_data;
                    REG_SEPARATOR_CHAR: pr_cfg.separator_char = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                n = parse_byte(rx_byte);
                if (typed_row >= 0)
                begin
                    // directed row with results typed in: these stand in for
                    // what the predictor would say
                    if (row_typed[typed_row] > 0)
                        pending_results.push_back(row_want0[typed_row]);
                    if (row_typed[typed_row] > 1)
                        pending_results.push_back(row_want1[typed_row]);
                    results_issued += row_typed[typed_row];
                end
                else
                begin
                    for (k = 0; k < n; k++)
                        pending_results.push_back(fresh[k]);
                    results_issued += n;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: value %0d index %0d", value, value_index);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (value !== want.value)
                    begin
                        $error("value: expected %0d, got %0d", want.value, value);
                        mismatches++;
                    end
                    if (value_index !== want.idx)
                    begin
                        $error("value_index: expected %0d, got %0d", want.idx, value_index);
                        mismatches++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, last);
                        mismatches++;
                    end
                    if (stop_frame !== want.stop)
                    begin
                        $error("stop_frame: expected %0b, got %0b", want.stop, stop_frame);
                        mismatches++;
                    end
                    if (clamped !== want.clamped)
                    begin
                        $error("clamped: expected %0b, got %0b", want.clamped, clamped);
                        mismatches++;
                    end
                    if (values_dropped !== want.dropped)
                    begin
                        $error("values_dropped: expected %0b, got %0b", want.dropped,
                               values_dropped);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stall, a calm window, and one long hold-off on
    // request from the sender so the readout backs up into in_stall.
    // ------------------------------------------------------------------
    initial
    begin : result_side
        int hold_left;
        int seen_seq;
        int cyc;
        hold_left = 0;
        seen_seq  = 0;
        cyc       = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_seq != seen_seq)
            begin
                seen_seq  = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (cyc >= 300 && cyc < 700)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Watchdog: ends the run once no request has moved for too long.
    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                stuck = 0;
            else
                stuck++;
        end
        $display("** framed_decimal_list_parser: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Byte request side
    // ------------------------------------------------------------------

    // Offer one byte and hold it until taken. row tags the last byte of a
    // directed row that has typed results, else -1.
    task automatic send_byte(input logic [7:0] b, input int row);
        while (!(rand_bytes >= 60 && rand_bytes < 150) &&
               $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        rx_byte   <= b;
        typed_row <= row;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait for every expected result, then let the block settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write all four registers on consecutive cycles; the block must be idle.
    task automatic load_cfg(input cfg_t c);
        cfg_we    <= 1'b1;
        cfg_index <= REG_EXPECTED_TAG;
        cfg_data  <= c.expected_tag;
        @(posedge clk);
        cfg_index <= REG_START_CHAR;
        cfg_data  <= c.start_char;
        @(posedge clk);
        cfg_index <= REG_END_CHAR;
        cfg_data  <= c.end_char;
        @(posedge clk);
        cfg_index <= REG_SEPARATOR_CHAR;
        cfg_data  <= c.separator_char;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_cfg = c;
    endtask

    function automatic void put(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            plan_bytes.push_back(s[i]);
    endfunction

    function automatic void end_row(input int ntyped, input frame_result_t w0,
                                    input frame_result_t w1);
        row_first.push_back(row_mark);
        row_len.push_back(plan_bytes.size() - row_mark);
        row_typed.push_back(ntyped);
        row_want0.push_back(w0);
        row_want1.push_back(w1);
        row_mark = plan_bytes.size();
    endfunction

    // Build one random frame for the current registers: mostly well formed,
    // with noise bytes, odd tags, long numbers, missing ends and frames that
    // run to the length limit mixed in.
    function automatic void build_frame();
        int nv;
        int nd;
        int k;
        int j;
        int pick;
        burst.delete();
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4)) burst.push_back(8'($urandom));
        burst.push_back(cur_cfg.start_char);
        pick = $urandom_range(0, 99);
        if (pick < 65)
            burst.push_back(cur_cfg.expected_tag);
        else if (pick < 80)
            burst.push_back(CH_STOP);
        else
            burst.push_back(8'($urandom));
        burst.push_back(($urandom_range(0, 9) < 7) ? cur_cfg.separator_char
                                                   : 8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            // straddle the length limit: some land just inside, some just past
            repeat ($urandom_range(MAX_LEN - 6, MAX_LEN - 2)) burst.push_back(CH_ZERO);
        end
        else
        begin
            nv = (pick < 15) ? $urandom_range(7, 11) : $urandom_range(1, 4);
            for (k = 0; k < nv; k++)
            begin
                if (k > 0)
                    burst.push_back(cur_cfg.separator_char);
                nd = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7)
                                                 : $urandom_range(0, 3);
                for (j = 0; j < nd; j++)
                begin
                    if ($urandom_range(0, 99) < 6)
                        burst.push_back(8'($urandom));
                    burst.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                end
            end
        end
        pick = $urandom_range(0, 99);
        if (pick < 86)
            burst.push_back(cur_cfg.end_char);
        else if (pick < 93)
            burst.push_back(CH_NEWLINE);
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        frame_result_t none;
        cfg_t          settings [0:4];
        int            r;
        int            i;
        int            p;
        int            phase_bytes;
        int            phase_mark;

        none = pack_result(0, 0, 1'b0, 1'b0, 1'b0, 1'b0);

        // Directed rows, all under the reset registers ('<' 'S' ',' '>').
        // Bytes outside any frame, both byte extremes among them, then a plain value.
        put(">x");
        plan_bytes.push_back(8'hFF);
        plan_bytes.push_back(8'h00);
        put("<S,5>");
        end_row(1, pack_result(5, 0, 1'b1, 1'b0, 1'b0, 1'b0), none);
        // stop frame, bare and with a body that must be ignored
        put("<s>");
        end_row(1, pack_result(0, 0, 1'b1, 1'b1, 1'b0, 1'b0), none);
        put("<s,9,abc>");
        end_row(1, pack_result(0, 0, 1'b1, 1'b1, 1'b0, 1'b0), none);
        // unknown tag, end before the tag, end in the separator slot
        put("<X,1,2>");
        end_row(0, none, none);
        put("<>");
        end_row(0, none, none);
        put("<S>");
        end_row(0, none, none);
        // empty value gives zero
        put("<S,>");
        end_row(1, pack_result(0, 0, 1'b1, 1'b0, 1'b0, 1'b0), none);
        // top of the range and one past it
        put("<S,65535,65536>");
        end_row(2, pack_result(65535, 0, 1'b0, 1'b0, 1'b0, 1'b0),
                pack_result(65535, 1, 1'b1, 1'b0, 1'b1, 1'b0));
        put("<S,99999999,0>");
        end_row(-1, none, none);
        put("<S,0,00065535>");
        end_row(-1, none, none);
        // a full store, then more values than it holds
        put("<S,1,2,3,4,5,6,7,8>");
        end_row(-1, none, none);
        put("<S,1,2,3,4,5,6,7,8,9,10>");
        end_row(-1, none, none);
        // any byte in the separator slot, stray letters inside values
        put("<S;12,3a4,,7 >");
        end_row(-1, none, none);
        // newline throws the frame away; the rest falls outside a frame
        put("<S,1\n2>");
        end_row(0, none, none);
        // a start marker inside a frame is just another byte
        put("<S,<3>");
        end_row(-1, none, none);
        // byte extremes inside a value
        put("<S,");
        plan_bytes.push_back(8'h00);
        put("7");
        plan_bytes.push_back(8'hFF);
        put("0>");
        end_row(-1, none, none);
        // end marker arriving as byte MAX_LEN + 1: discarded
        put("<S,");
        repeat (MAX_LEN - 3) put("0");
        put(">");
        end_row(0, none, none);
        // end marker as byte MAX_LEN: still inside the limit
        put("<S,");
        repeat (MAX_LEN - 4) put("0");
        put(">");
        end_row(1, pack_result(0, 0, 1'b1, 1'b0, 1'b0, 1'b0), none);

        // Register settings per phase: reset values, the two extreme sets
        // (stop letter as the tag; a digit as the separator), a random set,
        // and back to reset values for the pressure test.
        settings[0] = {RST_EXPECTED_TAG, RST_START_CHAR, RST_END_CHAR, RST_SEPARATOR_CHAR};
        settings[1] = {CH_STOP, 8'd0, 8'd255, 8'd0};
        settings[2] = {8'd255, 8'd255, 8'd0, 8'd53};
        settings[3] = {8'($urandom_range(33, 126)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
        settings[4] = settings[0];

        // Hold reset once at the start, then release it.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (p = 0; p < 5; p++)
        begin
            if (p > 0)
                wait_idle();
            load_cfg(settings[p]);

            if (p == 0)
            begin
                for (r = 0; r < row_first.size(); r++)
                    for (i = 0; i < row_len[r]; i++)
                        send_byte(plan_bytes[row_first[r] + i],
                                  (i == row_len[r] - 1 && row_typed[r] >= 0) ? r : -1);
                wait_idle();
            end

            if (p == 4)
            begin
                // Long receiver hold-off over a full store: the readout backs
                // up and in_stall rises while the next frame is still offered.
                hold_seq <= hold_seq + 1;
                burst.delete();
                cur_cfg = settings[4];
                for (i = 1; i <= MAX_VALS; i++)
                begin
                    burst.push_back((i == 1) ? RST_START_CHAR : RST_SEPARATOR_CHAR);
                    if (i == 1)
                    begin
                        burst.push_back(RST_EXPECTED_TAG);
                        burst.push_back(RST_SEPARATOR_CHAR);
                    end
                    burst.push_back(CH_ZERO + 8'(i));
                end
                burst.push_back(RST_END_CHAR);
                foreach (burst[i])
                    send_byte(burst[i], -1);
                build_frame();
                foreach (burst[i])
                    send_byte(burst[i], -1);
                // Pause until the backlog has fully drained.
                wait_idle();
            end

            phase_bytes = 0;
            phase_mark  = results_issued;
            while (phase_bytes < PHASE_BYTES ||
                   (results_issued - phase_mark < PHASE_HITS && phase_bytes < PHASE_CAP))
            begin
                build_frame();
                foreach (burst[i])
                begin
                    send_byte(burst[i], -1);
                    phase_bytes++;
                    rand_bytes++;
                end
            end
        end

        // Let the last results out, then a quiet tail.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("** framed_decimal_list_parser: PASSED **");
        else
            $display("** framed_decimal_list_parser: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
